@@ rtl/cta_pkg.sv @@
package cta_pkg;

    localparam int REG_COUNT = 6;
    localparam int REG_IDX_W = 3;
    localparam int ATAN_LEN  = 24;
    localparam int ROOT_W    = 24;
    localparam int NUM_W     = 48;
    localparam int CX_W      = 28;
    localparam int ANG_W     = 26;

    localparam logic signed [16:0] ANGLE_RIGHT = 17'sd5760;
    localparam logic signed [16:0] ANGLE_HALF  = 17'sd11520;
    localparam logic signed [16:0] ANGLE_FULL  = 17'sd23040;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_GXY = 3'd0,
        REG_X_GZO = 3'd1,
        REG_Y_GXY = 3'd2,
        REG_Y_GZO = 3'd3,
        REG_Z_GXY = 3'd4,
        REG_Z_GZO = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic               operation;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] cal_x;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_z;
        logic signed [15:0] tilt_angle;
    } result_t;

    // calibrated axes plus angle kind, carried beside the angle math
    typedef struct packed {
        logic signed [15:0] cal_x;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_z;
        logic               roll;
    } side_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [22:0] atan_deg16(input int i);
        logic [22:0] v;
        unique case (i)
            0:  v = 23'd2949120;
            1:  v = 23'd1740967;
            2:  v = 23'd919879;
            3:  v = 23'd466945;
            4:  v = 23'd234379;
            5:  v = 23'd117304;
            6:  v = 23'd58666;
            7:  v = 23'd29335;
            8:  v = 23'd14668;
            9:  v = 23'd7334;
            10: v = 23'd3667;
            11: v = 23'd1833;
            12: v = 23'd917;
            13: v = 23'd458;
            14: v = 23'd229;
            15: v = 23'd115;
            16: v = 23'd57;
            17: v = 23'd29;
            18: v = 23'd14;
            19: v = 23'd7;
            20: v = 23'd4;
            21: v = 23'd2;
            22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/calibrated_tilt_angle_core.sv @@
// Channel   Direction  Signals                               Word
// sample    in         sample_valid, sample_ready, sample    sample_t
// result    out        result_valid, result_ready, result    result_t
// cfg       in         cfg_valid, cfg_ready, cfg_index,      6 x 32-bit registers
//                      cfg_data
//
// Takes one word per cycle while no held result stalls the pipe. Stages: 3 calibration
// stages, 2 square/sum stages, 24 root stages (one root bit each), 1 CORDIC load,
// one stage per CORDIC rotation and the output register.
// Reset clears valid bits and calibration registers; data registers hold junk.
// A stalled result freezes the whole pipeline in place, so nothing is lost or
// repeated; sample_ready is low only while a result waits and result_ready is low.
module calibrated_tilt_angle_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  cta_pkg::sample_t                  sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output cta_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cta_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import cta_pkg::*;

    localparam int STG = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    logic [31:0]             cfg_reg [REG_COUNT];
    logic                    en;
    logic                    cal_valid, sq_valid, cor_valid;
    side_t                   cal_side, sq_side, cor_side;
    logic [ROOT_W-1:0]       root;
    logic                    cor_zero;
    logic signed [ANG_W-1:0] cor_ang;
    logic                    result_valid_reg;
    result_t                 result_reg, result_next;

    // whole pipe advances unless the output word is held
    assign en           = !result_valid_reg || result_ready;
    assign sample_ready = en;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_GXY: cfg_reg[REG_X_GXY] <= cfg_data;
                REG_X_GZO: cfg_reg[REG_X_GZO] <= cfg_data;
                REG_Y_GXY: cfg_reg[REG_Y_GXY] <= cfg_data;
                REG_Y_GZO: cfg_reg[REG_Y_GZO] <= cfg_data;
                REG_Z_GXY: cfg_reg[REG_Z_GXY] <= cfg_data;
                REG_Z_GZO: cfg_reg[REG_Z_GZO] <= cfg_data;
                default:   ;   // unknown index: dropped
            endcase
        end
    end

    cta_calib u_calib (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .in_word   (sample),
        .cfg_regs  (cfg_reg),
        .out_valid (cal_valid),
        .out_side  (cal_side)
    );

    cta_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cal_valid),
        .in_side   (cal_side),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (root)
    );

    cta_cordic #(
        .STAGES (STG)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_root   (root),
        .out_valid (cor_valid),
        .out_side  (cor_side),
        .out_zero  (cor_zero),
        .out_ang   (cor_ang)
    );

    // round to 1/64 degree, clamp, then fold by sign of z
    always_comb
    begin
        logic signed [ANG_W-1:0] rnd;
        logic signed [16:0]      a;
        logic signed [15:0]      top;
        top = cor_side.roll ? cor_side.cal_y : cor_side.cal_x;
        rnd = (cor_ang + ANG_W'(512)) >>> 10;
        if (cor_zero)
        begin
            if (top > 16'sd0)
                a = ANGLE_RIGHT;
            else if (top < 16'sd0)
                a = -ANGLE_RIGHT;
            else
                a = '0;
        end
        else if (rnd > ANG_W'(ANGLE_RIGHT))
            a = ANGLE_RIGHT;
        else if (rnd < -ANG_W'(ANGLE_RIGHT))
            a = -ANGLE_RIGHT;
        else
            a = rnd[16:0];

        if (cor_side.cal_z > 16'sd0)
        begin
            if (a < 17'sd0)
                a = a + ANGLE_FULL;
        end
        else if (cor_side.cal_z < 16'sd0)
            a = ANGLE_HALF - a;

        result_next.cal_x      = cor_side.cal_x;
        result_next.cal_y      = cor_side.cal_y;
        result_next.cal_z      = cor_side.cal_z;
        result_next.tilt_angle = a[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= cor_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/cta_calib.sv @@
module cta_calib (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cta_pkg::sample_t      in_word,
    input  logic [31:0]           cfg_regs [cta_pkg::REG_COUNT],
    output logic                  out_valid,
    output cta_pkg::side_t        out_side
);
    import cta_pkg::*;

    // stage 1: products, stage 2: sums, stage 3: round and saturate
    logic signed [31:0] prod_reg [3][3];
    logic signed [15:0] off_reg  [3];
    logic               roll1_reg, roll2_reg;
    logic signed [33:0] acc_reg  [3];
    logic signed [15:0] cal_reg  [3];
    logic               roll3_reg;
    logic [2:0]         valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a][0] <= $signed(cfg_regs[2*a][15:0]) * in_word.raw_x;
                prod_reg[a][1] <= $signed(cfg_regs[2*a][31:16]) * in_word.raw_y;
                prod_reg[a][2] <= $signed(cfg_regs[2*a+1][15:0]) * in_word.raw_z;
                off_reg[a]     <= $signed(cfg_regs[2*a+1][31:16]);
            end
            roll1_reg <= in_word.operation;

            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= 34'(prod_reg[a][0]) + 34'(prod_reg[a][1])
                            + 34'(prod_reg[a][2]) + (34'(off_reg[a]) <<< 6);
            end
            roll2_reg <= roll1_reg;

            for (int a = 0; a < 3; a++)
            begin
                logic signed [33:0] q;
                q = (acc_reg[a] + 34'sd32) >>> 6;
                if (q > 34'sd32767)
                    cal_reg[a] <= 16'sh7fff;
                else if (q < -34'sd32768)
                    cal_reg[a] <= 16'sh8000;
                else
                    cal_reg[a] <= q[15:0];
            end
            roll3_reg <= roll2_reg;
        end
    end

    assign out_valid      = valid_reg[2];
    assign out_side.cal_x = cal_reg[0];
    assign out_side.cal_y = cal_reg[1];
    assign out_side.cal_z = cal_reg[2];
    assign out_side.roll  = roll3_reg;

endmodule

@@ rtl/cta_sqrt.sv @@
module cta_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  cta_pkg::side_t                in_side,
    output logic                          out_valid,
    output cta_pkg::side_t                out_side,
    output logic [cta_pkg::ROOT_W-1:0]    out_root
);
    import cta_pkg::*;

    logic signed [15:0] bot;
    logic [30:0]        bsq_reg, zsq_reg;
    side_t              sq_side_reg;
    logic               sq_valid_reg;

    // one root bit per stage, most significant first
    logic [NUM_W:0]     rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]  root_reg [ROOT_W+1];
    side_t              side_reg [ROOT_W+1];
    logic [ROOT_W:0]    valid_reg;

    assign bot = in_side.roll ? in_side.cal_x : in_side.cal_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else if (en)
        begin
            sq_valid_reg <= in_valid;
            valid_reg    <= {valid_reg[ROOT_W-1:0], sq_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bsq_reg     <= 31'(bot * bot);
            zsq_reg     <= 31'(in_side.cal_z * in_side.cal_z);
            sq_side_reg <= in_side;
            rem_reg[0]  <= {1'b0, 32'(bsq_reg) + 32'(zsq_reg), 16'd0};
            root_reg[0] <= '0;
            side_reg[0] <= sq_side_reg;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_root
        localparam int K = ROOT_W - 1 - j;
        logic [NUM_W:0] cand;
        assign cand = ((NUM_W+1)'(root_reg[j]) << (K + 1)) + ((NUM_W+1)'(1) << (2 * K));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[j] >= cand)
                begin
                    rem_reg[j+1]  <= rem_reg[j] - cand;
                    root_reg[j+1] <= root_reg[j] | (ROOT_W'(1) << K);
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j];
                end
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];

endmodule

@@ rtl/cta_cordic.sv @@
module cta_cordic #(
    parameter int STAGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  cta_pkg::side_t                    in_side,
    input  logic [cta_pkg::ROOT_W-1:0]        in_root,
    output logic                              out_valid,
    output cta_pkg::side_t                    out_side,
    output logic                              out_zero,
    output logic signed [cta_pkg::ANG_W-1:0]  out_ang
);
    import cta_pkg::*;

    logic signed [CX_W-1:0]  x_reg   [STAGES+1];
    logic signed [CX_W-1:0]  y_reg   [STAGES+1];
    logic signed [ANG_W-1:0] ang_reg [STAGES+1];
    logic                    zero_reg[STAGES+1];
    side_t                   side_reg[STAGES+1];
    logic [STAGES:0]         valid_reg;
    logic signed [15:0]      top;

    assign top = in_side.roll ? in_side.cal_y : in_side.cal_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= $signed(CX_W'(in_root));
            y_reg[0]    <= CX_W'(top) <<< 8;
            ang_reg[0]  <= '0;
            zero_reg[0] <= (in_root == '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [CX_W-1:0]  xs, ys;
        logic signed [ANG_W-1:0] da;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign da = $signed(ANG_W'(atan_deg16(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][CX_W-1])
                begin
                    x_reg[i+1]   <= x_reg[i] + ys;
                    y_reg[i+1]   <= y_reg[i] - xs;
                    ang_reg[i+1] <= ang_reg[i] + da;
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - ys;
                    y_reg[i+1]   <= y_reg[i] + xs;
                    ang_reg[i+1] <= ang_reg[i] - da;
                end
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_side  = side_reg[STAGES];
    assign out_zero  = zero_reg[STAGES];
    assign out_ang   = ang_reg[STAGES];

endmodule

@@ rtl/cta_checker.sv @@
module cta_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_ready,
    input  logic              result_valid,
    input  logic              result_ready,
    input  cta_pkg::result_t  result
);
    import cta_pkg::*;

    // a held result word keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // input side only blocks when output word is stuck
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("sample stalled without output backpressure");

    // angle stays in its folded range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.tilt_angle >= -16'sd5760 && result.tilt_angle <= 16'sd23039)
        else $error("tilt angle out of range");

    // no word appears out of nothing on the first cycle after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

endmodule

bind calibrated_tilt_angle_core cta_checker u_cta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import cta_pkg::*;

    localparam int STAGES     = 16;
    localparam int LATENCY    = 31 + STAGES;
    localparam int RAND_WORDS = 1150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    always #5 clk = ~clk;

    calibrated_tilt_angle_core #(.CORDIC_STAGES(STAGES)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the calibration matrix
    logic [31:0] calib_regs [REG_COUNT];

    // Expected results, oldest first
    result_t pending_results[$];
    int      mismatch_count = 0;
    bit      sink_idle_ok = 1'b1;
    bit      hold_off = 1'b0;
    bit      stim_done = 1'b0;

    // Floor divide by 2^s (>>> on signed 64 bit is an arithmetic floor shift)
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] calib_axis(int axis, sample_t s);
        logic [31:0] gxy;
        logic [31:0] gzo;
        longint      acc;
        longint      q;
        gxy = calib_regs[2*axis];
        gzo = calib_regs[2*axis+1];
        acc = longint'($signed(gxy[15:0])) * longint'(s.raw_x)
            + longint'($signed(gxy[31:16])) * longint'(s.raw_y)
            + longint'($signed(gzo[15:0])) * longint'(s.raw_z)
            + longint'($signed(gzo[31:16])) * 64;
        q = fshr(acc + 32, 6);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(int i);
        case (i)
            0: return 2949120;   1: return 1740967;   2: return 919879;
            3: return 466945;    4: return 234379;    5: return 117304;
            6: return 58666;     7: return 29335;     8: return 14668;
            9: return 7334;      10: return 3667;     11: return 1833;
            12: return 917;      13: return 458;      14: return 229;
            15: return 115;      16: return 57;       17: return 29;
            18: return 14;       19: return 7;        20: return 4;
            21: return 2;        22: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [15:0] tilt_from(longint top, longint bot, longint z);
        longint r;
        longint x;
        longint y;
        longint ang;
        longint a;
        longint xs;
        longint ys;
        int     n;
        r = int_sqrt(longint'(bot * bot + z * z) << 16);
        if (r == 0)
            a = top > 0 ? 5760 : (top < 0 ? -5760 : 0);
        else
        begin
            x = r;
            y = top * 256;
            ang = 0;
            n = STAGES < 24 ? STAGES : 24;
            for (int i = 0; i < n; i++)
            begin
                xs = fshr(x, i);
                ys = fshr(y, i);
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    ang = ang + atan_step(i);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    ang = ang - atan_step(i);
                end
            end
            a = fshr(ang + 512, 10);
            if (a > 5760)
                a = 5760;
            if (a < -5760)
                a = -5760;
        end
        // quadrant fold by the sign of z
        if (z > 0)
        begin
            if (a < 0)
                a = a + 23040;
        end
        else if (z < 0)
            a = 11520 - a;
        return a[15:0];
    endfunction

    function automatic result_t tilt_expected(sample_t s);
        result_t r;
        r.cal_x = calib_axis(0, s);
        r.cal_y = calib_axis(1, s);
        r.cal_z = calib_axis(2, s);
        if (s.operation)
            r.tilt_angle = tilt_from(r.cal_y, r.cal_x, r.cal_z);
        else
            r.tilt_angle = tilt_from(r.cal_x, r.cal_y, r.cal_z);
        return r;
    endfunction

    // Register write, only while the pipeline is drained
    task automatic write_calib(cfg_reg_e idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        calib_regs[idx] = val;
    endtask

    task automatic load_matrix(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                               logic [31:0] v3, logic [31:0] v4, logic [31:0] v5);
        write_calib(REG_X_GXY, v0);
        write_calib(REG_X_GZO, v1);
        write_calib(REG_Y_GXY, v2);
        write_calib(REG_Y_GZO, v3);
        write_calib(REG_Z_GXY, v4);
        write_calib(REG_Z_GZO, v5);
    endtask

    task automatic drain_pipe();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Send one word; optional idle cycle first. Valid stays high back to back.
    task automatic send_word(sample_t s, bit may_idle);
        if (may_idle && $urandom_range(99) < 7)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        pending_results.push_back(tilt_expected(s));
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        s.raw_x = 16'($urandom);
        s.raw_y = 16'($urandom);
        s.raw_z = 16'($urandom);
        s.operation = 1'($urandom_range(1));
        // bias toward small readings, which are less likely to saturate
        if ($urandom_range(3) != 0)
        begin
            s.raw_x = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.raw_y = $signed(16'($urandom_range(4000))) - 16'sd2000;
            s.raw_z = $signed(16'($urandom_range(4000))) - 16'sd2000;
            if ($urandom_range(9) == 0)
                s.raw_z = '0;
        end
        return s;
    endfunction

    // Directed rows: expected angle typed in where obvious (-1 = use predictor)
    typedef struct {
        sample_t     s;
        int          exp_angle;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.cal_x !== result.cal_x || want.cal_y !== result.cal_y
                    || want.cal_z !== result.cal_z
                    || want.tilt_angle !== result.tilt_angle)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch exp x=%0d y=%0d z=%0d a=%0d",
                                  " got x=%0d y=%0d z=%0d a=%0d"},
                                 want.cal_x, want.cal_y, want.cal_z, want.tilt_angle,
                                 result.cal_x, result.cal_y, result.cal_z,
                                 result.tilt_angle);
                end
            end
        end
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_off)
            result_ready <= 1'b0;
        else if (sink_idle_ok)
            result_ready <= ($urandom_range(99) >= 7);
        else
            result_ready <= 1'b1;
    end

    initial
    begin
        int cnt;
        cnt = 0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        while (cnt < 200)
        begin
            @(posedge clk);
            cnt++;
        end
        hold_off = 1'b0;
    end

    initial
    begin
        sample_t s;
        dir_row_t row;
        for (int i = 0; i < REG_COUNT; i++)
            calib_regs[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: all gains zero, so every axis is 0 and the angle is 0
        s = '{raw_x: 16'sh7fff, raw_y: -16'sd32768, raw_z: 16'sd1, operation: 1'b0};
        send_word(s, 1'b0);
        sample_valid <= 1'b0;
        drain_pipe();

        // Identity-ish: gain 64 per count => cal = raw
        load_matrix(32'h0000_0040, 32'h0000_0000, 32'h0040_0000,
                    32'h0000_0000, 32'h0000_0000, 32'h0000_0040);
        // x, y, z, op, expected angle
        dir_rows.push_back('{'{16'sd1000, 16'sd0, 16'sd0, 1'b0}, 5760});
        dir_rows.push_back('{'{-16'sd1000, 16'sd0, 16'sd0, 1'b0}, -5760});
        dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 1'b0}, 0});
        dir_rows.push_back('{'{16'sd0, 16'sd1000, 16'sd0, 1'b1}, 5760});
        dir_rows.push_back('{'{16'sd0, -16'sd1000, 16'sd0, 1'b1}, -5760});
        dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd500, 1'b0}, 0});
        dir_rows.push_back('{'{16'sd0, 16'sd0, -16'sd500, 1'b1}, 11520});
        dir_rows.push_back('{'{16'sd300, 16'sd0, 16'sd300, 1'b0}, -1});
        dir_rows.push_back('{'{-16'sd300, 16'sd0, 16'sd300, 1'b0}, -1});
        dir_rows.push_back('{'{-16'sd300, 16'sd200, -16'sd300, 1'b0}, -1});
        dir_rows.push_back('{'{16'sd300, 16'sd200, -16'sd300, 1'b1}, -1});
        dir_rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}, -1});
        dir_rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1}, -1});
        dir_rows.push_back('{'{16'sd1, -16'sd1, 16'sd0, 1'b0}, -1});
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            send_word(row.s, 1'b0);
            if (row.exp_angle != -1)
                pending_results[$].tilt_angle = 16'(row.exp_angle);
        end
        sample_valid <= 1'b0;
        drain_pipe();

        // Extreme gains and offsets: saturation both ways
        load_matrix(32'h7fff_7fff, 32'h7fff_7fff, 32'h8000_8000,
                    32'h8000_8000, 32'h7fff_8000, 32'h0000_7fff);
        send_word('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0}, 1'b0);
        send_word('{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1}, 1'b0);
        send_word('{16'sh7fff, -16'sd32768, 16'sd0, 1'b0}, 1'b0);
        send_word('{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b0);
        sample_valid <= 1'b0;
        drain_pipe();

        // Random phases; phase 0 uses a fixed matrix, the others a fresh random one
        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 0)
                load_matrix(32'h0040_0040, 32'h0010_0040, 32'h0040_ffc0,
                            32'hfff0_0040, 32'hffc0_0040, 32'h0000_0040);
            else
                load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            sink_idle_ok = (ph != 2);
            for (int n = 0; n < RAND_WORDS / 4; n++)
                send_word(rand_sample(), ph != 2);
            sample_valid <= 1'b0;
            drain_pipe();
        end
        sink_idle_ok = 1'b1;

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
